/* sv/spimx_pkg.sv */
// ----------------------------------------------------------------------------
// spimx_pkg
// Shared types and constants for the SPI master byte exchange block.
// ----------------------------------------------------------------------------
`default_nettype none

package spimx_pkg;

  // Width of one exchanged word.
  localparam int unsigned SpimxDataBits = 8;

  // Action codes of an input item.
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE     = 3'd0;
  localparam logic [2:0] REG_LSB_FIRST  = 3'd1;
  localparam logic [2:0] REG_CLOCK_MODE = 3'd2;
  localparam logic [2:0] REG_DIVIDE_SEL = 3'd3;
  localparam logic [2:0] REG_IRQ_ENABLE = 3'd4;

  // Largest divider code that is honored; larger codes saturate here.
  localparam logic [2:0] DIV_SEL_MAX = 3'd6;

  // Input item.
  typedef struct packed {
    logic [1:0]               action;
    logic [SpimxDataBits-1:0] write_data;
    logic                     miso;
  } spimx_in_t;

  // Result item.
  typedef struct packed {
    logic                     sclk;
    logic                     mosi;
    logic [SpimxDataBits-1:0] read_data;
    logic                     done_flag;
    logic                     collision_flag;
    logic                     busy_res;
    logic                     irq;
  } spimx_out_t;

  // Configuration write request passed to the engine.
  typedef struct packed {
    logic       we;
    logic [2:0] index;
    logic [7:0] data;
  } spimx_cfg_wr_t;

endpackage : spimx_pkg

`default_nettype wire

/* sv/spi_master_byte_exchange.sv */
// ----------------------------------------------------------------------------
// spi_master_byte_exchange
// SPI master that exchanges one byte per start, modes 0 to 3, divider 2..128.
// ----------------------------------------------------------------------------
//   Channel  Direction  Ports                           Beat
//   in       input      in_valid, in_ready, in_data     one tick, write or read
//   out      output     out_valid, out_ready, out_data  one result per item
//   cfg      input      cfg_valid, cfg_ready, cfg_index, cfg_data  register write
//
// Each input beat updates the engine in the cycle it is accepted, and its
// result is queued; one beat per cycle is sustained while out_ready is high.
// The result register has a skid entry, so input stalls only when both hold.
// Reset is synchronous and active low; it restores register defaults.
// A configuration beat is always taken and holds off input in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module spi_master_byte_exchange
  import spimx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire spimx_in_t  in_data,
  output logic            out_valid,
  input  wire logic       out_ready,
  output spimx_out_t      out_data,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [2:0] cfg_index,
  input  wire logic [7:0] cfg_data
);

  spimx_cfg_wr_t cfg_wr;
  spimx_out_t    result;
  logic          can_push;
  logic          item_acc;

  // Configuration writes take priority over input beats.
  assign cfg_ready    = 1'b1;
  assign cfg_wr.we    = cfg_valid;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  assign in_ready = can_push & ~cfg_valid;
  assign item_acc = in_valid & in_ready;

  // SPI engine.
  spimx_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_wr   (cfg_wr),
    .item_acc (item_acc),
    .item     (in_data),
    .result   (result)
  );

  // Result register and skid entry.
  spimx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (item_acc),
    .push_data (result),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // Interrupt is only raised while the done flag shown is set.
  a_irq_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.irq |-> out_data.done_flag)
    else $error("irq without done flag");

  // Input is held off only by configuration or a full result queue.
  a_stall_has_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready && !cfg_valid |-> out_valid)
    else $error("input stalled with empty result queue");

  // No result is shown right after reset.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule : spi_master_byte_exchange

`default_nettype wire

/* sv/spimx_core.sv */
// ----------------------------------------------------------------------------
// spimx_core
// SPI engine: configuration registers, divider, serial clock and shifter.
// ----------------------------------------------------------------------------
`default_nettype none

module spimx_core
  import spimx_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire spimx_cfg_wr_t cfg_wr,
  input  wire logic          item_acc,
  input  wire spimx_in_t     item,
  output spimx_out_t         result
);

  localparam int unsigned DataBits = SpimxDataBits;
  localparam int unsigned CountW   = $clog2(DataBits + 1);

  // Shift one sampled bit into the word in the selected order.
  function automatic logic [DataBits-1:0] shift_in(
    input logic [DataBits-1:0] sr,
    input logic                bitv,
    input logic                lsb
  );
    logic [DataBits-1:0] res;
    if (lsb) begin
      res = {bitv, sr[DataBits-1:1]};
    end else begin
      res = {sr[DataBits-2:0], bitv};
    end
    return res;
  endfunction

  // Configuration registers.
  logic       enable_r, enable_nxt;
  logic       lsb_first_r, lsb_first_nxt;
  logic [1:0] clock_mode_r, clock_mode_nxt;
  logic [2:0] divide_sel_r, divide_sel_nxt;
  logic       irq_en_r, irq_en_nxt;

  // Engine state.
  logic [DataBits-1:0] shift_r, shift_nxt;
  logic [CountW-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [6:0]          half_cnt_r, half_cnt_nxt;
  logic                clk_lvl_r, clk_lvl_nxt;
  logic                edge_ph_r, edge_ph_nxt;
  logic                active_r, active_nxt;
  logic                complete_r, complete_nxt;
  logic                collided_r, collided_nxt;
  logic [DataBits-1:0] rx_buf_r, rx_buf_nxt;
  logic                sampled_r, sampled_nxt;

  logic [2:0] div_sat;
  logic [6:0] half_period;
  logic [6:0] half_inc;
  logic       leading;

  // Half period of the serial clock in system ticks.
  assign div_sat     = (divide_sel_r > DIV_SEL_MAX) ? DIV_SEL_MAX : divide_sel_r;
  assign half_period = 7'd1 << div_sat;
  assign half_inc    = half_cnt_r + 7'd1;
  assign leading     = ~edge_ph_r;

  // Next state for a configuration write or an accepted item.
  always_comb begin
    enable_nxt     = enable_r;
    lsb_first_nxt  = lsb_first_r;
    clock_mode_nxt = clock_mode_r;
    divide_sel_nxt = divide_sel_r;
    irq_en_nxt     = irq_en_r;
    shift_nxt      = shift_r;
    bit_cnt_nxt    = bit_cnt_r;
    half_cnt_nxt   = half_cnt_r;
    clk_lvl_nxt    = clk_lvl_r;
    edge_ph_nxt    = edge_ph_r;
    active_nxt     = active_r;
    complete_nxt   = complete_r;
    collided_nxt   = collided_r;
    rx_buf_nxt     = rx_buf_r;
    sampled_nxt    = sampled_r;

    if (cfg_wr.we) begin
      unique case (cfg_wr.index)
        REG_ENABLE:     enable_nxt     = cfg_wr.data[0];
        REG_LSB_FIRST:  lsb_first_nxt  = cfg_wr.data[0];
        REG_CLOCK_MODE: clock_mode_nxt = cfg_wr.data[1:0];
        REG_DIVIDE_SEL: divide_sel_nxt = cfg_wr.data[2:0];
        REG_IRQ_ENABLE: irq_en_nxt     = cfg_wr.data[0];
        default: ;
      endcase
      // A known register write re-idles the engine unless it keeps running.
      if (cfg_wr.index <= REG_IRQ_ENABLE && (!enable_nxt || !active_r)) begin
        active_nxt   = 1'b0;
        bit_cnt_nxt  = '0;
        half_cnt_nxt = '0;
        edge_ph_nxt  = 1'b0;
        clk_lvl_nxt  = clock_mode_nxt[1];
      end
    end else if (item_acc) begin
      unique case (item.action)
        ACT_TICK: begin
          if (enable_r && active_r) begin
            half_cnt_nxt = half_inc;
            if (half_inc >= half_period) begin
              half_cnt_nxt = '0;
              clk_lvl_nxt  = ~clk_lvl_r;
              edge_ph_nxt  = ~edge_ph_r;
              if (!clock_mode_r[0]) begin
                // Sample on the leading edge, shift on the trailing edge.
                if (leading) begin
                  sampled_nxt = item.miso;
                end else begin
                  shift_nxt   = shift_in(shift_r, sampled_r, lsb_first_r);
                  bit_cnt_nxt = bit_cnt_r + 1'b1;
                end
              end else begin
                // Shift on the leading edge, sample on the trailing edge.
                if (leading) begin
                  if (bit_cnt_r != '0) begin
                    shift_nxt = shift_in(shift_r, sampled_r, lsb_first_r);
                  end
                end else begin
                  sampled_nxt = item.miso;
                  bit_cnt_nxt = bit_cnt_r + 1'b1;
                  if (bit_cnt_nxt >= CountW'(DataBits)) begin
                    shift_nxt = shift_in(shift_r, item.miso, lsb_first_r);
                  end
                end
              end
              // Last bit done: latch the word and return to idle.
              if (!leading && bit_cnt_nxt >= CountW'(DataBits)) begin
                rx_buf_nxt   = shift_nxt;
                complete_nxt = 1'b1;
                active_nxt   = 1'b0;
                bit_cnt_nxt  = '0;
                half_cnt_nxt = '0;
                edge_ph_nxt  = 1'b0;
                clk_lvl_nxt  = clock_mode_r[1];
              end
            end
          end
        end
        ACT_WRITE: begin
          if (enable_r) begin
            if (active_r) begin
              collided_nxt = 1'b1;
            end else begin
              shift_nxt    = item.write_data;
              sampled_nxt  = 1'b0;
              bit_cnt_nxt  = '0;
              half_cnt_nxt = '0;
              edge_ph_nxt  = 1'b0;
              clk_lvl_nxt  = clock_mode_r[1];
              active_nxt   = 1'b1;
            end
          end
        end
        ACT_READ: begin
          complete_nxt = 1'b0;
          collided_nxt = 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Result of the item, taken from the updated state; a read shows the flags before clearing them.
  always_comb begin
    result.sclk      = clk_lvl_nxt;
    result.mosi      = lsb_first_r ? shift_nxt[0] : shift_nxt[DataBits-1];
    result.read_data = rx_buf_nxt;
    if (item.action == ACT_READ) begin
      result.done_flag      = complete_r;
      result.collision_flag = collided_r;
    end else begin
      result.done_flag      = complete_nxt;
      result.collision_flag = collided_nxt;
    end
    result.busy_res = active_nxt;
    result.irq      = complete_nxt & irq_en_r;
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r     <= 1'b0;
      lsb_first_r  <= 1'b0;
      clock_mode_r <= 2'd0;
      divide_sel_r <= 3'd1;
      irq_en_r     <= 1'b0;
      shift_r      <= '0;
      bit_cnt_r    <= '0;
      half_cnt_r   <= '0;
      clk_lvl_r    <= 1'b0;
      edge_ph_r    <= 1'b0;
      active_r     <= 1'b0;
      complete_r   <= 1'b0;
      collided_r   <= 1'b0;
      rx_buf_r     <= '0;
      sampled_r    <= 1'b0;
    end else begin
      enable_r     <= enable_nxt;
      lsb_first_r  <= lsb_first_nxt;
      clock_mode_r <= clock_mode_nxt;
      divide_sel_r <= divide_sel_nxt;
      irq_en_r     <= irq_en_nxt;
      shift_r      <= shift_nxt;
      bit_cnt_r    <= bit_cnt_nxt;
      half_cnt_r   <= half_cnt_nxt;
      clk_lvl_r    <= clk_lvl_nxt;
      edge_ph_r    <= edge_ph_nxt;
      active_r     <= active_nxt;
      complete_r   <= complete_nxt;
      collided_r   <= collided_nxt;
      rx_buf_r     <= rx_buf_nxt;
      sampled_r    <= sampled_nxt;
    end
  end

endmodule : spimx_core

`default_nettype wire

/* sv/spimx_out_buf.sv */
// ----------------------------------------------------------------------------
// spimx_out_buf
// Result register with a skid entry, so a stalled output stops input only once both hold.
// ----------------------------------------------------------------------------
`default_nettype none

module spimx_out_buf
  import spimx_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire spimx_out_t push_data,
  output logic            can_push,
  output logic            out_valid,
  input  wire logic       out_ready,
  output spimx_out_t      out_data
);

  logic       main_vld_r, main_vld_nxt;
  logic       skid_vld_r, skid_vld_nxt;
  spimx_out_t main_r, main_nxt;
  spimx_out_t skid_r, skid_nxt;
  logic       pop;

  assign pop       = main_vld_r & out_ready;
  assign can_push  = ~skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_data  = main_r;

  // Two-entry queue: the skid entry refills the main entry on a pop.
  always_comb begin
    main_vld_nxt = main_vld_r;
    skid_vld_nxt = skid_vld_r;
    main_nxt     = main_r;
    skid_nxt     = skid_r;
    if (push && !pop) begin
      if (!main_vld_r) begin
        main_nxt     = push_data;
        main_vld_nxt = 1'b1;
      end else begin
        skid_nxt     = push_data;
        skid_vld_nxt = 1'b1;
      end
    end else if (pop && !push) begin
      if (skid_vld_r) begin
        main_nxt     = skid_r;
        skid_vld_nxt = 1'b0;
      end else begin
        main_vld_nxt = 1'b0;
      end
    end else if (pop && push) begin
      if (skid_vld_r) begin
        main_nxt = skid_r;
        skid_nxt = push_data;
      end else begin
        main_nxt = push_data;
      end
    end
  end

  // Valid bits take reset; the payload entries do not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else begin
      main_vld_r <= main_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    main_r <= main_nxt;
    skid_r <= skid_nxt;
  end

endmodule : spimx_out_buf

`default_nettype wire
